// ===== design/lbs_pkg.sv =====
// lbs_pkg: shared types and constants of the longest bitonic subsequence core
// no dependencies; compile first

package lbs_pkg;

	localparam int VALUE_W = 16;
	localparam int LEN_W   = 5;

	// word handed from the front end to the search engine
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      store;
		logic                      last;
		logic                      ovf;
	} lbs_word_t;

endpackage

// ===== design/lbs_sample_if.sv =====
// lbs_sample_if: input channel of the core, valid/ready with one sample per word
// depends on lbs_pkg

interface lbs_sample_if import lbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] sample_value;
	logic                      last_sample;

	modport source (output valid, sample_value, last_sample, input ready);
	modport sink (input valid, sample_value, last_sample, output ready);
endinterface

// ===== design/lbs_result_if.sv =====
// lbs_result_if: output channel of the core, one chosen element per word
// depends on lbs_pkg

interface lbs_result_if import lbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [LEN_W-1:0]          best_length;
	logic signed [VALUE_W-1:0] chosen_value;
	logic                      final_element;
	logic                      overflow_flag;

	modport source (output valid, best_length, chosen_value, final_element, overflow_flag,
		input ready);
	modport sink (input valid, best_length, chosen_value, final_element, overflow_flag,
		output ready);
endinterface

// ===== design/longest_bitonic_subsequence_core.sv =====
// longest_bitonic_subsequence_core: top level, front end, word queue and search engine
// depends on lbs_pkg, lbs_sample_if, lbs_result_if, lbs_front, lbs_queue, lbs_back
//
//   channel  | dir | word contents                                        | accepted when
//   sample   | in  | sample_value, last_sample                            | valid && ready
//   result   | out | best_length, chosen_value, final_element, overflow   | valid && ready
//
// loading takes one sample per cycle unless the engine is busy; a two-word queue sits
// between front end and engine. after the last sample the table pass walks the rows
// from last to first, one memory read per cycle; the engine then fetches the first
// chosen word, and each further word is found by a forward scan after the word before it.
// reset clears control only; the sample store holds no value until written.
// result words hold in their register while ready is low; samples queue meanwhile.

module longest_bitonic_subsequence_core import lbs_pkg::*; #(
	parameter int MAX_SAMPLES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	lbs_sample_if.sink   sample,
	lbs_result_if.source result
);

	logic      push_valid;
	logic      push_ready;
	lbs_word_t push_word;
	logic      pop_valid;
	logic      pop_ready;
	lbs_word_t pop_word;

	lbs_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word)
	);

	lbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_word   (pop_word)
	);

	lbs_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_word  (pop_word),
		.result    (result)
	);

endmodule

// ===== design/lbs_front.sv =====
// lbs_front: accepts samples, tracks fill and overflow, tags each word for the engine
// depends on lbs_pkg and lbs_sample_if

module lbs_front import lbs_pkg::*; #(
	parameter int MAX_SAMPLES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	lbs_sample_if.sink       sample,
	output logic             push_valid,
	input  logic             push_ready,
	output lbs_word_t        push_word
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_SAMPLES);

	logic [CW-1:0] fill_q;
	logic          ovf_q;
	logic          room;
	logic          take;

	assign room         = fill_q < MAX_C;
	assign take         = sample.valid && push_ready;
	assign sample.ready = push_ready;
	assign push_valid   = sample.valid;
	assign push_word    = '{value: sample.sample_value, store: room,
		last: sample.last_sample, ovf: ovf_q | ~room};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (take) begin
			if (sample.last_sample) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				fill_q <= fill_q + CW'(room);
				ovf_q  <= ovf_q | ~room;
			end
		end
	end

endmodule

// ===== design/lbs_queue.sv =====
// lbs_queue: two-entry word queue between front end and search engine
// depends on lbs_pkg

module lbs_queue import lbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  lbs_word_t push_word,
	output logic      pop_valid,
	input  logic      pop_ready,
	output lbs_word_t pop_word
);

	lbs_word_t  slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] used_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = used_q != 2'd2;
	assign pop_valid  = used_q != 2'd0;
	assign pop_word   = slot_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			used_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			used_q <= used_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// ===== design/lbs_back.sv =====
// lbs_back: sample store, length tables, search sequencer and result register
// depends on lbs_pkg and lbs_result_if

module lbs_back import lbs_pkg::*; #(
	parameter int MAX_SAMPLES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  lbs_word_t   pop_word,
	lbs_result_if.source result
);

	localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	typedef enum logic [7:0] {
		ST_LOAD  = 8'b0000_0001,
		ST_TROW  = 8'b0000_0010,
		ST_TVAL  = 8'b0000_0100,
		ST_TSCAN = 8'b0000_1000,
		ST_EROW  = 8'b0001_0000,
		ST_EVAL  = 8'b0010_0000,
		ST_EMIT  = 8'b0100_0000,
		ST_ESCAN = 8'b1000_0000
	} lbs_state_t;

	logic signed [VALUE_W-1:0] smem [MAX_SAMPLES];
	logic [CW-1:0]             fmem [MAX_SAMPLES];
	logic [CW-1:0]             bmem [MAX_SAMPLES];

	lbs_state_t                state_q;
	logic [CW-1:0]             cnt_q;
	logic [IW-1:0]             row_q;
	logic [CW-1:0]             col_q;
	logic [CW-1:0]             best_q;
	logic [IW-1:0]             cur_q;
	logic [CW-1:0]             need_q;
	logic                      falling_q;
	logic                      ovf_q;
	logic                      rd_v_s1;
	logic [IW-1:0]             col_s1;
	logic signed [VALUE_W-1:0] rd_val_s1;
	logic [CW-1:0]             rd_fall_s1;
	logic [CW-1:0]             rd_bit_s1;
	logic signed [VALUE_W-1:0] pivot_q;
	logic signed [VALUE_W-1:0] cur_val_q;
	logic [CW-1:0]             bf_q;
	logic [CW-1:0]             bb_q;

	logic [IW-1:0]             rd_addr;
	logic                      scanning;
	logic                      issue;
	logic                      fall_hit;
	logic                      rise_hit;
	logic                      hit;
	logic                      scan_done;
	logic [CW-1:0]             cnt_next;
	logic [CW-1:0]             fall_new;
	logic [CW-1:0]             row_len;
	logic [CW-1:0]             bf_next;
	logic [CW-1:0]             bb_next;
	logic [CW+LEN_W-1:0]       len_wide;

	assign scanning  = (state_q == ST_TSCAN) || (state_q == ST_ESCAN);
	assign fall_hit  = (state_q == ST_ESCAN) && rd_v_s1 && (rd_val_s1 < cur_val_q)
		&& (rd_fall_s1 >= need_q);
	assign rise_hit  = (state_q == ST_ESCAN) && rd_v_s1 && !falling_q
		&& (rd_val_s1 > cur_val_q) && (rd_bit_s1 >= need_q);
	assign hit       = fall_hit || rise_hit;
	assign issue     = scanning && (col_q < cnt_q) && !hit;
	assign scan_done = (col_q >= cnt_q) && !rd_v_s1;
	assign cnt_next  = cnt_q + CW'(pop_word.store);
	assign fall_new  = bf_q + CW'(1);
	assign row_len   = bb_q + CW'(1);
	assign pop_ready = state_q == ST_LOAD;

	always_comb begin
		bf_next = bf_q;
		bb_next = bb_q;
		if (rd_v_s1) begin
			if (rd_val_s1 < pivot_q) begin
				if (rd_fall_s1 > bf_q) bf_next = rd_fall_s1;
				if (rd_fall_s1 > bb_q) bb_next = rd_fall_s1;
			end else if (rd_val_s1 > pivot_q) begin
				if (rd_bit_s1 > bb_q) bb_next = rd_bit_s1;
			end
		end
	end

	always_comb begin
		case (state_q)
			ST_TROW: rd_addr = row_q;
			ST_EROW: rd_addr = cur_q;
			default: rd_addr = col_q[IW-1:0];
		endcase
	end

	// memories and datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && pop_valid && pop_word.store) begin
			smem[cnt_q[IW-1:0]] <= pop_word.value;
		end
		if (state_q == ST_TSCAN && scan_done) begin
			fmem[row_q] <= fall_new;
			bmem[row_q] <= row_len;
		end
		rd_val_s1  <= smem[rd_addr];
		rd_fall_s1 <= fmem[rd_addr];
		rd_bit_s1  <= bmem[rd_addr];
		col_s1     <= col_q[IW-1:0];
		case (state_q)
			ST_TVAL: begin
				pivot_q <= rd_val_s1;
				bf_q    <= '0;
				bb_q    <= '0;
			end
			ST_TSCAN: begin
				bf_q <= bf_next;
				bb_q <= bb_next;
			end
			ST_EVAL: begin
				cur_val_q <= rd_val_s1;
			end
			ST_ESCAN: begin
				if (hit) cur_val_q <= rd_val_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			row_q     <= '0;
			col_q     <= '0;
			best_q    <= '0;
			cur_q     <= '0;
			need_q    <= '0;
			falling_q <= 1'b0;
			ovf_q     <= 1'b0;
			rd_v_s1   <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (issue) col_q <= col_q + CW'(1);
			case (state_q)
				ST_LOAD: begin
					if (pop_valid) begin
						cnt_q <= cnt_next;
						if (pop_word.last) begin
							ovf_q   <= pop_word.ovf;
							best_q  <= '0;
							row_q   <= IW'(cnt_next - CW'(1));
							state_q <= ST_TROW;
						end
					end
				end
				ST_TROW: state_q <= ST_TVAL;
				ST_TVAL: begin
					col_q   <= CW'(row_q) + CW'(1);
					state_q <= ST_TSCAN;
				end
				ST_TSCAN: begin
					if (scan_done) begin
						if (row_len >= best_q) begin
							best_q <= row_len;
							cur_q  <= row_q;
						end
						if (row_q == '0) begin
							state_q <= ST_EROW;
						end else begin
							row_q   <= row_q - IW'(1);
							state_q <= ST_TROW;
						end
					end
				end
				ST_EROW: state_q <= ST_EVAL;
				ST_EVAL: begin
					need_q    <= best_q;
					falling_q <= 1'b0;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (result.ready) begin
						if (need_q == CW'(1)) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							need_q  <= need_q - CW'(1);
							col_q   <= CW'(cur_q) + CW'(1);
							state_q <= ST_ESCAN;
						end
					end
				end
				ST_ESCAN: begin
					if (hit) begin
						cur_q   <= col_s1;
						if (fall_hit) falling_q <= 1'b1;
						state_q <= ST_EMIT;
					end else if (scan_done) begin
						cnt_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign len_wide             = {{LEN_W{1'b0}}, best_q};
	assign result.valid         = state_q == ST_EMIT;
	assign result.best_length   = len_wide[LEN_W-1:0];
	assign result.chosen_value  = cur_val_q;
	assign result.final_element = need_q == CW'(1);
	assign result.overflow_flag = ovf_q;

endmodule

// ===== design/lbs_checker.sv =====
// lbs_checker: port-level assertions on the result channel of the core
// depends on lbs_pkg; bound to longest_bitonic_subsequence_core

module lbs_checker import lbs_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [LEN_W-1:0]          best_length,
	input logic signed [VALUE_W-1:0] chosen_value,
	input logic                      final_element,
	input logic                      overflow_flag
);

	logic                      acc;
	logic                      in_burst_q;
	logic [LEN_W-1:0]          seen_q;
	logic [LEN_W-1:0]          len_q;
	logic signed [VALUE_W-1:0] prev_q;

	assign acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_burst_q <= 1'b0;
			seen_q     <= '0;
		end else if (acc) begin
			in_burst_q <= !final_element;
			seen_q     <= final_element ? '0 : seen_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			len_q  <= best_length;
			prev_q <= chosen_value;
		end
	end

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chosen_value)
			&& $stable(best_length) && $stable(final_element) && $stable(overflow_flag))
		else $error("result word changed while stalled");

	// one length per subsequence
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_burst_q |-> best_length == len_q)
		else $error("length changed within a subsequence");

	// neighbors never equal
	a_strict: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_burst_q |-> chosen_value != prev_q)
		else $error("equal neighbors in subsequence");

	// word count matches length
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && final_element |-> seen_q + LEN_W'(1) == best_length)
		else $error("word count differs from length");

endmodule

bind longest_bitonic_subsequence_core lbs_checker u_lbs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.best_length   (result.best_length),
	.chosen_value  (result.chosen_value),
	.final_element (result.final_element),
	.overflow_flag (result.overflow_flag)
);

// ===== verif/testbench.sv =====
// testbench: self-checking bench for longest_bitonic_subsequence_core, directed then random sets
// depends on lbs_pkg, lbs_sample_if, lbs_result_if and the core; predicts every chosen word

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lbs_pkg::*;

	localparam int MAX_SAMPLES = 16;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_SAMPLES = 245;

	typedef struct packed {
		logic [LEN_W-1:0]          length;
		logic signed [VALUE_W-1:0] value;
		logic                      final_mark;
		logic                      dropped;
	} pick_t;

	logic clk;
	logic arst_n;

	lbs_sample_if sample_ch ();
	lbs_result_if result_ch ();

	longest_bitonic_subsequence_core #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch)
	);

	logic signed [VALUE_W-1:0] held[MAX_SAMPLES];
	int                        held_count;
	bit                        dropped_seen;
	pick_t                     picks_due[$];
	logic signed [VALUE_W-1:0] set_buf[$];

	bit steady;
	int fault_count;
	int quiet_cycles;
	int samples_sent;
	int sets_sent;
	int sets_overflowed;
	int picks_checked;

	always #4 clk = ~clk;

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 5);
	endfunction

	// walk the loaded set backwards, then follow the lexicographically first longest path
	function automatic void plan_picks();
		int  fall_run[MAX_SAMPLES];
		int  peak_run[MAX_SAMPLES];
		int  n, best, cur, need, emitted, j, fb, pb;
		bit  descending, found;
		pick_t p;
		n = held_count;
		for (int i = n - 1; i >= 0; i--) begin
			fb = 0;
			pb = 0;
			for (j = i + 1; j < n; j++) begin
				if (held[j] < held[i]) begin
					if (fall_run[j] > fb) fb = fall_run[j];
					if (fall_run[j] > pb) pb = fall_run[j];
				end else if (held[j] > held[i]) begin
					if (peak_run[j] > pb) pb = peak_run[j];
				end
			end
			fall_run[i] = fb + 1;
			peak_run[i] = pb + 1;
		end
		best = 0;
		cur = 0;
		for (int i = 0; i < n; i++) begin
			if (peak_run[i] > best) begin
				best = peak_run[i];
				cur = i;
			end
		end
		need = best;
		emitted = 0;
		descending = 1'b0;
		while (need > 0 && emitted < MAX_SAMPLES) begin
			p.length = LEN_W'(best);
			p.value = held[cur];
			p.final_mark = (need == 1);
			p.dropped = dropped_seen;
			picks_due.push_back(p);
			emitted++;
			need--;
			if (need > 0) begin
				j = cur + 1;
				found = 1'b0;
				while (j < n && !found) begin
					if (held[j] < held[cur] && fall_run[j] >= need) begin
						descending = 1'b1;
						found = 1'b1;
					end else if (!descending && held[j] > held[cur] && peak_run[j] >= need) begin
						found = 1'b1;
					end else begin
						j++;
					end
				end
				if (found) cur = j;
				else need = 0;
			end
		end
	endfunction

	function automatic void absorb_sample(input logic signed [VALUE_W-1:0] v, input logic lst);
		if (held_count < MAX_SAMPLES) begin
			held[held_count] = v;
			held_count++;
		end else begin
			dropped_seen = 1'b1;
		end
		if (lst) begin
			if (dropped_seen) sets_overflowed++;
			plan_picks();
			held_count = 0;
			dropped_seen = 1'b0;
			sets_sent++;
		end
	endfunction

	task automatic push_sample(input logic signed [VALUE_W-1:0] v, input logic lst);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.sample_value <= v;
		sample_ch.last_sample  <= lst;
		do @(posedge clk); while (!sample_ch.ready);
		absorb_sample(v, lst);
		samples_sent++;
	endtask

	task automatic send_set();
		foreach (set_buf[k]) push_sample(set_buf[k], k == set_buf.size() - 1);
	endtask

	function automatic void check_pick();
		pick_t p;
		if (picks_due.size() == 0) begin
			$error("unexpected result word, chosen_value %0d", result_ch.chosen_value);
			fault_count++;
		end else begin
			p = picks_due.pop_front();
			picks_checked++;
			if (result_ch.best_length !== p.length) begin
				$error("best_length: expected %0d, actual %0d", p.length, result_ch.best_length);
				fault_count++;
			end
			if (result_ch.chosen_value !== p.value) begin
				$error("chosen_value: expected %0d, actual %0d", p.value,
					result_ch.chosen_value);
				fault_count++;
			end
			if (result_ch.final_element !== p.final_mark) begin
				$error("final_element: expected %0d, actual %0d", p.final_mark,
					result_ch.final_element);
				fault_count++;
			end
			if (result_ch.overflow_flag !== p.dropped) begin
				$error("overflow_flag: expected %0d, actual %0d", p.dropped,
					result_ch.overflow_flag);
				fault_count++;
			end
		end
	endfunction

	task automatic test_single_sample();
		set_buf = '{16'sh7FFF};
		send_set();
	endtask

	task automatic test_equal_neighbours();
		set_buf = '{-16'sd32768, -16'sd32768};
		send_set();
	endtask

	// full store, then a dropped word that also closes the set
	task automatic test_store_full();
		set_buf.delete();
		set_buf.push_back(-16'sd32768);
		for (int k = 1; k < 8; k++) set_buf.push_back(VALUE_W'(k * 1000));
		set_buf.push_back(16'sd32767);
		for (int k = 7; k > 0; k--) set_buf.push_back(VALUE_W'(k * 900 - 4000));
		set_buf.push_back(-16'sd1);
		send_set();
	endtask

	task automatic test_flag_cleared();
		set_buf = '{16'sd1, 16'sd2, 16'sd1};
		send_set();
	endtask

	task automatic build_set(input int len);
		int                        style;
		int                        peak;
		logic signed [VALUE_W-1:0] v;
		style = $urandom_range(0, 9);
		peak = $urandom_range(0, len - 1);
		v = VALUE_W'($urandom());
		set_buf.delete();
		for (int k = 0; k < len; k++) begin
			if (style < 4) begin
				v = VALUE_W'($urandom_range(0, 8)) - 16'sd4;
			end else if (style < 7) begin
				v = VALUE_W'($urandom());
			end else if ($urandom_range(0, 7) == 0) begin
				v = v + VALUE_W'($urandom_range(0, 64)) - 16'sd32;
			end else if (k <= peak) begin
				v = v + VALUE_W'($urandom_range(0, 300));
			end else begin
				v = v - VALUE_W'($urandom_range(0, 300));
			end
			set_buf.push_back(v);
		end
	endtask

	task automatic test_random_sets();
		int start;
		int r;
		int len;
		start = samples_sent;
		while (samples_sent - start < RANDOM_SAMPLES) begin
			r = $urandom_range(0, 9);
			if (r < 6) len = $urandom_range(1, 8);
			else if (r < 9) len = $urandom_range(9, MAX_SAMPLES);
			else len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 4);
			steady = ($urandom_range(0, 3) == 0);
			build_set(len);
			send_set();
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) check_pick();
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready) ||
			(result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("[longest_bitonic_subsequence_core] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random hold-off before each word
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_value = '0;
		sample_ch.last_sample = 1'b0;
		held_count = 0;
		dropped_seen = 1'b0;
		steady = 1'b0;
		fault_count = 0;
		quiet_cycles = 0;
		samples_sent = 0;
		sets_sent = 0;
		sets_overflowed = 0;
		picks_checked = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_single_sample();
		test_equal_neighbours();
		test_store_full();
		test_flag_cleared();
		test_random_sets();
		sample_ch.valid <= 1'b0;

		while (picks_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d sets of %0d samples loaded, %0d with dropped samples",
			sets_sent, samples_sent, sets_overflowed);
		$display("%0d chosen words checked, %0d mismatches", picks_checked, fault_count);
		if (fault_count == 0) begin
			$display("[longest_bitonic_subsequence_core] OK");
		end else begin
			$display("[longest_bitonic_subsequence_core] ERROR");
		end
		$finish;
	end

endmodule

// ===== longest_bitonic_subsequence_core.f =====
design/lbs_pkg.sv
design/lbs_sample_if.sv
design/lbs_result_if.sv
design/lbs_front.sv
design/lbs_queue.sv
design/lbs_back.sv
design/longest_bitonic_subsequence_core.sv
design/lbs_checker.sv
verif/testbench.sv
